// ----- hdl/gst_pkg.sv -----
// shared types and constants of the two-gate speed trap
package gst_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned DIST_W  = 20;
	localparam int unsigned SPEED_W = 32;
	localparam int unsigned SCALE_W = 14;
	// dividend width: distance times the scale factor
	localparam int unsigned NUM_W   = DIST_W + SCALE_W;
	localparam int unsigned CNT_W   = $clog2(NUM_W + 1);
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [SCALE_W-1:0] SPEED_SCALE = SCALE_W'(10000);
	localparam logic [SPEED_W-1:0] SPEED_MAX   = '1;

	localparam logic [TIME_W-1:0]  LOCKOUT_RST  = TIME_W'(50000);
	localparam logic [DIST_W-1:0]  DISTANCE_RST = DIST_W'(100000);
	localparam logic [SPEED_W-1:0] LIMIT_RST    = SPEED_W'(3000);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = CFG_IDX_W'(2);

	// sequencer states of the top level
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_FINISH
	} gst_state_t;

	// status from the divider back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} gst_div_stat_t;

endpackage

// ----- hdl/two_gate_speed_trap_unit.sv -----
// Two-gate speed trap: lockout filter, start time capture and speed division.
//
// Input channel: in_valid/in_stall carry one sensor event (event_time,
// gate_a_fall, gate_b_fall). A request is taken when in_valid is high and
// in_stall is low. Output channel: out_valid/out_stall carry one speed
// result; it is taken when out_valid is high and out_stall is low.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Index 0 lockout, 1 gate distance, 2 speed limit.
// Events with no gate flag, events inside the lockout window and start gate
// events give no result; the block goes from the check state back to idle.
// A stop gate event runs a 34-step restoring divider (one quotient bit per
// cycle through a single shared subtractor); the block takes no new request
// until the result has gone to the output register.
// A zero interval skips the divider and goes straight to the finish state.
// The finished result sits in an output register; the block keeps taking
// requests while it waits, and holds a new result until the receiver takes
// the old one. Reset clears state, restores register defaults and drops any
// pending result.
module two_gate_speed_trap_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [gst_pkg::TIME_W-1:0]       event_time,
	input  logic                             gate_a_fall,
	input  logic                             gate_b_fall,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [gst_pkg::SPEED_W-1:0]      speed_hundredths,
	output logic                             over_limit,
	output logic                             zero_interval,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gst_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gst_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import gst_pkg::*;

	gst_state_t           state_q, state_d;

	logic [TIME_W-1:0]    lockout_q;
	logic [DIST_W-1:0]    distance_q;
	logic [SPEED_W-1:0]   limit_q;
	logic [TIME_W-1:0]    last_q;
	logic [TIME_W-1:0]    start_q;

	logic [TIME_W-1:0]    time_q;
	logic                 gate_a_q;
	logic                 gate_b_q;
	logic [SPEED_W-1:0]   speed_q;
	logic                 zero_q;

	logic                 out_valid_q;
	logic [SPEED_W-1:0]   out_speed_q;
	logic                 out_over_q;
	logic                 out_zero_q;

	logic [TIME_W-1:0]    since_last;
	logic [TIME_W-1:0]    interval;
	logic                 take;
	logic                 zero_int;
	logic [NUM_W-1:0]     num;
	logic                 in_ready;
	logic                 div_start;
	logic                 load_out;
	gst_div_stat_t        div_stat;
	logic [SPEED_W-1:0]   div_quot;

	// event qualification from the captured request
	always_comb begin
		since_last = time_q - last_q;
		interval   = time_q - start_q;
		take       = (gate_a_q | gate_b_q) && (since_last > lockout_q);
		zero_int   = (interval == '0);
		num        = NUM_W'(distance_q) * NUM_W'(SPEED_SCALE);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!take || gate_a_q) state_d = ST_IDLE;
				else if (zero_int)     state_d = ST_FINISH;
				else                   state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		div_start = (state_q == ST_CHECK) && take && !gate_a_q && !zero_int;
		load_out  = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	end

	assign in_stall  = ~in_ready;
	assign cfg_ready = 1'b1;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q  <= LOCKOUT_RST;
			distance_q <= DISTANCE_RST;
			limit_q    <= LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LOCKOUT:  lockout_q  <= cfg_data[TIME_W-1:0];
				CFG_DISTANCE: distance_q <= cfg_data[DIST_W-1:0];
				CFG_LIMIT:    limit_q    <= cfg_data[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	// last accepted event and start time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			start_q <= '0;
		end else if (state_q == ST_CHECK && take) begin
			last_q <= time_q;
			if (gate_a_q) start_q <= time_q;
		end
	end

	// request capture and speed holding register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			time_q   <= event_time;
			gate_a_q <= gate_a_fall;
			gate_b_q <= gate_b_fall;
		end
		if (state_q == ST_CHECK) begin
			speed_q <= SPEED_MAX;
			zero_q  <= zero_int;
		end else if (state_q == ST_DIV && div_stat.done) begin
			speed_q <= div_quot;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload with over-limit compare
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_speed_q <= speed_q;
			out_over_q  <= (speed_q > limit_q);
			out_zero_q  <= zero_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign speed_hundredths = out_speed_q;
	assign over_limit       = out_over_q;
	assign zero_interval    = out_zero_q;

	// shared divider
	gst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (interval),
		.stat   (div_stat),
		.quot   (div_quot)
	);

endmodule

// ----- hdl/gst_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle, saturating result
module gst_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [gst_pkg::NUM_W-1:0]     num,
	input  logic [gst_pkg::TIME_W-1:0]    den,
	output gst_pkg::gst_div_stat_t        stat,
	output logic [gst_pkg::SPEED_W-1:0]   quot
);
	import gst_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [NUM_W-1:0]    num_q;
	logic [NUM_W-1:0]    quot_q;
	logic [TIME_W-1:0]   den_q;
	logic [TIME_W-1:0]   rem_q;
	logic [TIME_W:0]     trial;
	logic [TIME_W+1:0]   diff;
	logic                ge;

	// shared subtract and compare: one trial subtraction per cycle
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		diff  = {1'b0, trial} - {2'b00, den_q};
		ge    = ~diff[TIME_W+1];
	end

	// step counter and handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			rem_q  <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
			quot_q <= {quot_q[NUM_W-2:0], ge};
		end
	end

	// saturate quotients that do not fit the speed width
	assign quot = (|quot_q[NUM_W-1:SPEED_W]) ? SPEED_MAX : quot_q[SPEED_W-1:0];
	assign stat = '{busy: busy_q, done: done_q};

endmodule
